### design/hashed_token_bag_vectorizer_assert.svh
// Assertion macros for the hashed token bag vectorizer.
// Used by the top-level module hashed_token_bag_vectorizer; needs a signal named clk and one named rst.
`ifndef HASHED_TOKEN_BAG_VECTORIZER_ASSERT_SVH
`define HASHED_TOKEN_BAG_VECTORIZER_ASSERT_SVH

// Check on every clock edge outside of reset.
`define HTBV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define HTBV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/htbv_pkg.sv
// Shared widths, codes and types of the hashed token bag vectorizer.
// No dependencies; used by the interfaces, the bin store and the top level.
package htbv_pkg;

  // Vector size and the widths that follow from it
  localparam int DIM         = 256;
  localparam int IDX_W       = $clog2(DIM);
  localparam int ACTION_W    = 2;
  localparam int BYTE_W      = 8;
  localparam int BIN_INDEX_W = 8;
  localparam int COUNT_W     = 16;
  localparam int SUM_W       = 39;
  localparam int TOTAL_W     = 32;
  localparam int HASH_W      = 32;
  // Exact sum of squares: each square is below 2^(2*COUNT_W-1), DIM of them
  localparam int SQ_W        = 2 * COUNT_W - 1 + IDX_W;
  localparam int SUM_INT_W   = (SQ_W > SUM_W) ? SQ_W : SUM_W;

  // FNV-1a constants
  localparam logic [HASH_W-1:0] HASH_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;

  // Saturation limits of one bin count
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

  // Request codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_BYTE  = 2'd0,
    ACT_END   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  // Result codes
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // Commands from the controller to the bin store
  typedef struct packed {
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic signed [COUNT_W-1:0]  wr_data;
    logic                       clear;
  } bin_op_t;

endpackage

### design/htbv_if.sv
// Valid/ready channel interfaces of the hashed token bag vectorizer.
// Depends on htbv_pkg for field widths.
interface htbv_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [htbv_pkg::ACTION_W-1:0]        action;
  logic [htbv_pkg::BYTE_W-1:0]          text_byte;
  logic [htbv_pkg::BIN_INDEX_W-1:0]     bin_index;

  modport source (output valid, action, text_byte, bin_index, input ready);
  modport sink   (input valid, action, text_byte, bin_index, output ready);
endinterface

interface htbv_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 result_kind;
  logic signed [htbv_pkg::COUNT_W-1:0]  bin_value;
  logic [htbv_pkg::SUM_W-1:0]           sum_of_squares;
  logic [htbv_pkg::TOTAL_W-1:0]         token_total;

  modport source (output valid, result_kind, bin_value, sum_of_squares, token_total,
                  input ready);
  modport sink   (input valid, result_kind, bin_value, sum_of_squares, token_total,
                  output ready);
endinterface

### design/htbv_bin_store.sv
// Bin count store: one synchronous RAM with a registered read port and per-entry valid bits.
// Depends on htbv_pkg; an entry never written since reset or clear reads as zero.
module htbv_bin_store (
  input  logic                                clk,
  input  logic                                rst,
  input  htbv_pkg::bin_op_t                   op,
  output logic signed [htbv_pkg::COUNT_W-1:0] rd_data
);

  logic signed [htbv_pkg::COUNT_W-1:0] mem [htbv_pkg::DIM];
  logic [htbv_pkg::DIM-1:0]            vld;
  logic signed [htbv_pkg::COUNT_W-1:0] rd_word;
  logic                                rd_vld;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (op.wr_en) begin
      mem[op.wr_addr] <= op.wr_data;
    end
    if (op.rd_en) begin
      rd_word <= mem[op.rd_addr];
    end
  end

  // Drop all entries at once on reset or clear, mark entries as they are written
  always_ff @(posedge clk) begin
    if (rst || op.clear) begin
      vld <= '0;
    end else if (op.wr_en) begin
      vld[op.wr_addr] <= 1'b1;
    end
  end

  // Capture the valid bit alongside the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (op.rd_en) begin
      rd_vld <= vld[op.rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_word : '0;

endmodule

### design/hashed_token_bag_vectorizer.sv
// Hashed token bag vectorizer. A text byte that extends a token is taken in S_IDLE: the FNV-1a
// multiply is registered straight into the running hash. A byte that ends a token first reads
// the bin count from the store RAM, then writes it back in S_RMW along with the sum of squares.
// End of text goes to S_SUMMARY, through S_RMW first when it closes a token; a bin read goes
// through the RAM read, then the result register in S_READ. A clear drops every bin at once
// through the store's valid bits, so there is no clearing pass after reset. Each request is
// handled to completion before the next is taken; a finished result waits in the output
// register and does not hold up requests that produce none.
module hashed_token_bag_vectorizer (
  input  logic        clk,
  input  logic        rst,
  htbv_req_if.sink    req,
  htbv_res_if.source  res
);

  localparam int DW = htbv_pkg::COUNT_W + 2;
  localparam logic signed [DW-1:0] ONE_D = DW'(1);
  localparam logic [htbv_pkg::SUM_W-1:0] SUM_OUT_MAX = {htbv_pkg::SUM_W{1'b1}};
  localparam logic [htbv_pkg::TOTAL_W-1:0] TOTAL_MAX = {htbv_pkg::TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SUMMARY,
    S_READ
  } state_t;

  state_t                                state;
  logic [htbv_pkg::HASH_W-1:0]           running_hash;
  logic                                  in_token;
  logic [htbv_pkg::SUM_INT_W-1:0]        square_sum;
  logic [htbv_pkg::TOTAL_W-1:0]          token_counter;
  logic                                  end_pending;
  logic                                  read_in_range;
  logic                                  res_valid;
  logic                                  res_load;

  htbv_pkg::bin_op_t                     bin_op;
  logic signed [htbv_pkg::COUNT_W-1:0]   bin_op_store_data;
  logic signed [htbv_pkg::COUNT_W-1:0]   old_count;
  logic signed [htbv_pkg::COUNT_W-1:0]   new_count;
  logic signed [DW-1:0]                  old_x;
  logic signed [DW-1:0]                  delta;
  logic signed [htbv_pkg::SUM_INT_W-1:0] delta_x;
  logic [htbv_pkg::SUM_INT_W-1:0]        square_sum_next;
  logic [htbv_pkg::SUM_W-1:0]            sum_out;
  logic [htbv_pkg::BYTE_W-1:0]           folded_byte;
  logic [htbv_pkg::HASH_W-1:0]           hash_next;
  logic [htbv_pkg::IDX_W-1:0]            hash_bin;
  logic                                  tok_char;
  logic                                  accept;
  logic                                  out_free;
  htbv_pkg::action_t                     action;

  // Token characters: ASCII letters, digits and underscore
  function automatic logic is_token_byte(input logic [htbv_pkg::BYTE_W-1:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  assign accept   = req.valid && req.ready;
  assign out_free = !res_valid || res.ready;
  assign action   = htbv_pkg::action_t'(req.action);
  assign res_load = ((state == S_SUMMARY) || (state == S_READ)) && out_free;

  // Fold to lower case and advance the hash by one byte
  assign tok_char    = is_token_byte(req.text_byte);
  assign folded_byte = (req.text_byte >= "A" && req.text_byte <= "Z") ?
                       (req.text_byte | 8'h20) : req.text_byte;
  assign hash_next   = (running_hash ^ htbv_pkg::HASH_W'(folded_byte)) * htbv_pkg::HASH_PRIME;
  assign hash_bin    = htbv_pkg::IDX_W'(running_hash % htbv_pkg::HASH_W'(htbv_pkg::DIM));

  // Step the count read from the store and the matching change of its square
  assign old_count = bin_op_store_data;
  assign old_x     = DW'(old_count);
  always_comb begin
    new_count = old_count;
    delta     = '0;
    if (running_hash[0]) begin
      if (old_count != htbv_pkg::COUNT_MIN) begin
        new_count = old_count - htbv_pkg::COUNT_W'(1);
        delta     = ONE_D - (old_x <<< 1);
      end
    end else begin
      if (old_count != htbv_pkg::COUNT_MAX) begin
        new_count = old_count + htbv_pkg::COUNT_W'(1);
        delta     = ONE_D + (old_x <<< 1);
      end
    end
  end
  assign delta_x         = htbv_pkg::SUM_INT_W'(delta);
  assign square_sum_next = square_sum + $unsigned(delta_x);

  // Clip the reported sum of squares
  assign sum_out = (square_sum > htbv_pkg::SUM_INT_W'(SUM_OUT_MAX)) ?
                   SUM_OUT_MAX : square_sum[htbv_pkg::SUM_W-1:0];

  // Store commands
  always_comb begin
    bin_op         = '0;
    bin_op.wr_addr = hash_bin;
    bin_op.wr_data = new_count;
    bin_op.rd_addr = hash_bin;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            htbv_pkg::ACT_BYTE:  bin_op.rd_en = !tok_char && in_token;
            htbv_pkg::ACT_END:   bin_op.rd_en = in_token;
            htbv_pkg::ACT_READ: begin
              bin_op.rd_en   = 1'b1;
              bin_op.rd_addr = htbv_pkg::IDX_W'(req.bin_index);
            end
            htbv_pkg::ACT_CLEAR: bin_op.clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_RMW:     bin_op.wr_en = 1'b1;
      S_SUMMARY: ;
      S_READ:    ;
      default:   ;
    endcase
  end

  htbv_bin_store u_store (
    .clk     (clk),
    .rst     (rst),
    .op      (bin_op),
    .rd_data (bin_op_store_data)
  );

  assign req.ready = (state == S_IDLE);
  assign res.valid = res_valid;

  // Controller state, vector totals and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_hash  <= htbv_pkg::HASH_BASIS;
      in_token      <= 1'b0;
      square_sum    <= '0;
      token_counter <= '0;
      end_pending   <= 1'b0;
      read_in_range <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      // Load a finished reply, drop the one taken by the receiver
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (action)
              htbv_pkg::ACT_BYTE: begin
                if (tok_char) begin
                  running_hash <= hash_next;
                  in_token     <= 1'b1;
                end else if (in_token) begin
                  end_pending <= 1'b0;
                  state       <= S_RMW;
                end
              end
              htbv_pkg::ACT_END: begin
                end_pending <= 1'b1;
                state       <= in_token ? S_RMW : S_SUMMARY;
              end
              htbv_pkg::ACT_READ: begin
                read_in_range <= (32'(req.bin_index) < 32'(htbv_pkg::DIM));
                state         <= S_READ;
              end
              htbv_pkg::ACT_CLEAR: begin
                running_hash  <= htbv_pkg::HASH_BASIS;
                in_token      <= 1'b0;
                square_sum    <= '0;
                token_counter <= '0;
              end
              default: ;
            endcase
          end
        end
        S_RMW: begin
          square_sum   <= square_sum_next;
          running_hash <= htbv_pkg::HASH_BASIS;
          in_token     <= 1'b0;
          if (token_counter != TOTAL_MAX) begin
            token_counter <= token_counter + htbv_pkg::TOTAL_W'(1);
          end
          state <= end_pending ? S_SUMMARY : S_IDLE;
        end
        S_SUMMARY: begin
          if (out_free) begin
            res.result_kind    <= htbv_pkg::KIND_SUMMARY;
            res.bin_value      <= '0;
            res.sum_of_squares <= sum_out;
            res.token_total    <= token_counter;
            state              <= S_IDLE;
          end
        end
        S_READ: begin
          if (out_free) begin
            res.result_kind    <= htbv_pkg::KIND_READ;
            res.bin_value      <= read_in_range ? bin_op_store_data : '0;
            res.sum_of_squares <= '0;
            res.token_total    <= '0;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "hashed_token_bag_vectorizer_assert.svh"

  `HTBV_ASSERT(a_clear_zeroes, (accept && action == htbv_pkg::ACT_CLEAR) |=> (square_sum == '0 && token_counter == '0), "clear left totals nonzero")
  `HTBV_ASSERT(a_sep_rmw, (accept && action == htbv_pkg::ACT_BYTE && !tok_char && in_token) |=> (state == S_RMW), "token end did not start a read-modify-write")
  `HTBV_ASSERT(a_count_step, (token_counter != $past(token_counter)) |-> (token_counter == '0 || token_counter == $past(token_counter) + htbv_pkg::TOTAL_W'(1)), "token total jumped")
  `HTBV_ASSERT(a_summary_flushed, (state == S_SUMMARY) |-> (!in_token && running_hash == htbv_pkg::HASH_BASIS), "summary with a pending token")
  `HTBV_ASSERT_ALWAYS(a_store_excl, !(bin_op.wr_en && bin_op.clear), "store write during clear")

endmodule

### test/htbv_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the hashed token bag vectorizer: mirrors token hashing and bin counts,
// predicts each reply and compares it field by field with the one leaving the block.
// Depends on htbv_pkg and the channel interfaces in htbv_if.sv.
module htbv_checker (
  input  logic clk,
  input  logic rst,
  htbv_req_if  req,
  htbv_res_if  res,
  output int   errors,
  output int   outstanding
);
  import htbv_pkg::*;

  localparam longint SUM_LIMIT = (longint'(1) << SUM_W) - 1;

  typedef struct packed {
    logic                      kind;
    logic signed [COUNT_W-1:0] value;
    logic [SUM_W-1:0]          sumsq;
    logic [TOTAL_W-1:0]        total;
  } reply_t;

  reply_t replies_due[$];

  // Mirror of the block's state
  logic [HASH_W-1:0]         hash_acc;
  logic                      in_word;
  logic signed [COUNT_W-1:0] word_counts [DIM];
  longint                    sq_exact;
  logic [TOTAL_W-1:0]        tokens_seen;

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  // Fold the finished token into its bin, then restart the hash
  task automatic close_word();
    logic [IDX_W-1:0]          slot;
    logic signed [COUNT_W-1:0] was, now;
    longint                    was_sq, now_sq;
    if (!in_word) return;
    slot = IDX_W'(hash_acc % DIM);
    was  = word_counts[slot];
    now  = was;
    // Odd hash counts down, even hash counts up, both saturating
    if (hash_acc[0]) begin
      if (now != COUNT_MIN) now = now - 1;
    end else if (now != COUNT_MAX) begin
      now = now + 1;
    end
    word_counts[slot] = now;
    was_sq = was;
    was_sq = was_sq * was_sq;
    now_sq = now;
    now_sq = now_sq * now_sq;
    sq_exact = sq_exact - was_sq + now_sq;
    if (tokens_seen != '1) tokens_seen = tokens_seen + 1'b1;
    hash_acc = HASH_BASIS;
    in_word  = 1'b0;
  endtask

  // Zero the vector and drop any partial token
  task automatic wipe();
    foreach (word_counts[i]) word_counts[i] = '0;
    sq_exact    = 0;
    tokens_seen = '0;
    hash_acc    = HASH_BASIS;
    in_word     = 1'b0;
  endtask

  // Update the mirror with one accepted request and queue its reply, if any
  task automatic apply_request(action_t act, logic [7:0] c, logic [7:0] idx);
    logic [7:0] folded;
    reply_t     reply;
    case (act)
      ACT_BYTE: begin
        if (is_word_char(c)) begin
          folded   = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
          hash_acc = (hash_acc ^ HASH_W'(folded)) * HASH_PRIME;
          in_word  = 1'b1;
        end else begin
          close_word();
        end
      end
      ACT_END: begin
        close_word();
        reply.kind  = KIND_SUMMARY;
        reply.value = '0;
        reply.sumsq = (sq_exact > SUM_LIMIT) ? SUM_W'(SUM_LIMIT) : SUM_W'(sq_exact);
        reply.total = tokens_seen;
        replies_due.insert(replies_due.size(), reply);
      end
      ACT_READ: begin
        reply.kind  = KIND_READ;
        reply.value = (int'(idx) < DIM) ? word_counts[IDX_W'(idx)] : '0;
        reply.sumsq = '0;
        reply.total = '0;
        replies_due.insert(replies_due.size(), reply);
      end
      default: wipe();
    endcase
  endtask

  always @(posedge clk) begin
    reply_t due;
    if (rst) begin
      wipe();
      replies_due.delete();
      errors = 0;
    end else begin
      // Compare the reply leaving the block with the oldest one due
      if (res.valid && res.ready) begin
        if (replies_due.size() == 0) begin
          $error("result with none due: result_kind %0d", res.result_kind);
          errors++;
        end else begin
          due = replies_due.pop_front();
          if (res.result_kind !== due.kind) begin
            $error("result_kind: expected %0d, actual %0d", due.kind, res.result_kind);
            errors++;
          end
          if (res.bin_value !== due.value) begin
            $error("bin_value: expected %0d, actual %0d", due.value, res.bin_value);
            errors++;
          end
          if (res.sum_of_squares !== due.sumsq) begin
            $error("sum_of_squares: expected %0d, actual %0d", due.sumsq, res.sum_of_squares);
            errors++;
          end
          if (res.token_total !== due.total) begin
            $error("token_total: expected %0d, actual %0d", due.total, res.token_total);
            errors++;
          end
        end
      end
      // Predict from the request taken at this edge
      if (req.valid && req.ready) begin
        apply_request(action_t'(req.action), req.text_byte, req.bin_index);
      end
    end
    outstanding = replies_due.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Top of the hashed token bag vectorizer testbench: clock, reset, request and reply traffic,
// watchdog and verdict. Needs htbv_pkg, htbv_if.sv, htbv_checker and the block itself.
module tb;
  import htbv_pkg::*;

  localparam int RANDOM_ITEMS   = 1450;
  localparam int CALM_ITEMS     = 250;
  localparam int HOLD_AT        = 500;
  localparam int PAUSE_AT       = 900;
  localparam int HOLD_CYCLES    = 200;
  localparam int PAIR_TOKENS    = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;
  // Bins of the one-letter tokens "a" (even hash) and "b" (odd hash)
  localparam logic [7:0] BIN_OF_A = 8'h2C;
  localparam logic [7:0] BIN_OF_B = 8'hE5;

  logic clk;
  logic rst;
  int   fail_count;
  int   replies_pending;
  int   sent;
  int   holds_asked;
  int   holds_served;
  bit   calm;
  bit   gaps_on;

  htbv_req_if req_ch ();
  htbv_res_if res_ch ();

  hashed_token_bag_vectorizer DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  htbv_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .res         (res_ch),
    .errors      (fail_count),
    .outstanding (replies_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request from a falling edge, hold until taken, then maybe idle
  task automatic put_req(action_t act, logic [7:0] c, logic [7:0] idx);
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.text_byte <= c;
    req_ch.bin_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
    if (gaps_on && !calm && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_req(ACT_BYTE, s[i], 8'($urandom));
  endtask

  // Stop offering and wait for every reply still due
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (replies_pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 3))
      0:       return 8'("a" + $urandom_range(0, 25));
      1:       return 8'("A" + $urandom_range(0, 25));
      2:       return 8'("0" + $urandom_range(0, 9));
      default: return "_";
    endcase
  endfunction

  // Pick a byte from one of the non-token ranges
  function automatic logic [7:0] sep_char();
    case ($urandom_range(0, 5))
      0:       return 8'($urandom_range(0, 47));
      1:       return 8'($urandom_range(58, 64));
      2:       return 8'($urandom_range(91, 94));
      3:       return 8'h60;
      4:       return 8'($urandom_range(123, 255));
      default: return " ";
    endcase
  endfunction

  task automatic put_random_word(bit terminate);
    repeat ($urandom_range(1, 8)) put_req(ACT_BYTE, word_char(), 8'($urandom));
    if (terminate) begin
      repeat ($urandom_range(1, 2)) put_req(ACT_BYTE, sep_char(), 8'($urandom));
    end
  endtask

  // Request side
  initial begin
    int pick;
    bit paused;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.action    = ACT_BYTE;
    req_ch.text_byte = '0;
    req_ch.bin_index = '0;
    gaps_on          = 1'b1;
    calm             = 1'b0;
    paused           = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Case folding, high-byte separator, flush of a pending token at end of text
    put_text("Ab_9");
    put_req(ACT_BYTE, 8'hFF, 8'h00);
    put_text("z0");
    put_req(ACT_END, 8'h00, 8'hFF);
    put_req(ACT_READ, 8'hFF, 8'h00);
    put_req(ACT_READ, 8'h00, 8'hFF);
    // Clear in the middle of a token leaves nothing behind
    put_text("qR");
    put_req(ACT_CLEAR, 8'hFF, 8'hFF);
    put_req(ACT_END, 8'h00, 8'h00);
    // Separators right next to each token character range
    put_text("_/9:A@Z[`{");
    put_req(ACT_READ, 8'h00, 8'hAA);
    put_req(ACT_END, 8'h00, 8'h00);

    // Drive one bin up and one bin down with back-to-back tokens, then read both
    gaps_on = 1'b0;
    put_req(ACT_CLEAR, 8'h00, 8'h00);
    repeat (PAIR_TOKENS) put_text("a ");
    repeat (PAIR_TOKENS) put_text("b ");
    put_req(ACT_READ, 8'h00, BIN_OF_A);
    put_req(ACT_READ, 8'h00, BIN_OF_B);
    put_req(ACT_END, 8'h00, 8'h00);
    put_req(ACT_CLEAR, 8'h00, 8'h00);
    gaps_on = 1'b1;

    // Mostly well-formed text with reads, ends and clears mixed in, plus some noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
      if (holds_asked == 0 && sent >= HOLD_AT) holds_asked = 1;
      if (!paused && sent >= PAUSE_AT) begin
        paused = 1'b1;
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        put_random_word(1'b1);
      end else if (pick < 80) begin
        put_req(ACT_READ, 8'($urandom), 8'($urandom));
      end else if (pick < 88) begin
        if ($urandom_range(0, 1)) put_random_word(1'b0);
        put_req(ACT_END, 8'($urandom), 8'($urandom));
      end else if (pick < 91) begin
        if ($urandom_range(0, 1)) put_random_word(1'b0);
        put_req(ACT_CLEAR, 8'($urandom), 8'($urandom));
      end else begin
        put_req(action_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Reply side: short random stalls, one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (holds_served != holds_asked) begin
        holds_served++;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // End the run when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
